// ===== rtl/core/length_prefixed_frame_checker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Length-prefixed frame checker assertion macros
// Shared concurrent assertion wrappers for the frame checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_CHECKER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_CHECKER_TOP_DEFINES_SVH

// Checked only outside reset.
`define LPFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LPFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame checker package
// Constants, status codes and the result type of the frame checker.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    localparam int unsigned MAX_PAYLOAD = 65535;
    localparam int unsigned HDR_LEN     = 3;
    localparam int unsigned POS_LIMIT   = HDR_LEN + MAX_PAYLOAD;
    localparam int unsigned POS_SAT     = POS_LIMIT + 1;
    localparam int unsigned POS_W       = $clog2(POS_SAT + 1);

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT_HDR  = 3'd1,
        ST_SHORT_BODY = 3'd2,
        ST_TRAILING   = 3'd3,
        ST_OVERLONG   = 3'd4
    } status_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
        status_t     frame_status;
        logic [7:0]  frame_kind;
        logic [15:0] declared_length;
    } res_t;

endpackage

// ===== rtl/core/lpfc_byte_if.sv =====
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel carrying one raw frame byte and its last flag.
// ----------------------------------------------------------------------------
interface lpfc_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);

endinterface

// ===== rtl/core/lpfc_result_if.sv =====
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one per-byte result of the frame checker.
// ----------------------------------------------------------------------------
interface lpfc_result_if;

    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [2:0]  frame_status;
    logic [7:0]  frame_kind;
    logic [15:0] declared_length;

    modport source (
        output valid, output payload_valid, output payload_byte, output frame_end,
        output frame_status, output frame_kind, output declared_length,
        input  ready
    );
    modport sink (
        input  valid, input payload_valid, input payload_byte, input frame_end,
        input  frame_status, input frame_kind, input declared_length,
        output ready
    );

endinterface

// ===== rtl/core/length_prefixed_frame_checker_top.sv =====
// Frame checker: takes one frame byte per cycle on byte_ch while byte_ch.ready
// is high and returns one registered result per byte on result_ch, sustaining
// one transfer per cycle while result_ch.ready is high. The result is held in
// a registered output stage backed by a one-entry skid buffer, so a byte is
// still taken in the cycle the result side first stalls; byte_ch.ready drops
// only once both entries hold results. Bytes inside the declared length come
// out with payload_valid set; the frame_last byte carries frame_end, status,
// header kind and length (zero on a short header) and clears the frame state.
// ----------------------------------------------------------------------------
// Length-prefixed frame checker top level
// Header parsing, payload marking and end-of-frame status, with output buffer.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker_top
    import lpfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lpfc_byte_if.sink     byte_ch,
    lpfc_result_if.source result_ch
);

    logic push_valid;
    logic push_ready;
    res_t push_data;

    lpfc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    lpfc_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .result_ch  (result_ch)
    );

endmodule

// ===== rtl/core/lpfc_core.sv =====
// ----------------------------------------------------------------------------
// Frame checker core
// Tracks the byte position and header fields and builds one result per byte.
// ----------------------------------------------------------------------------
module lpfc_core
    import lpfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    lpfc_byte_if.sink        byte_ch,
    input  logic             push_ready,
    output logic             push_valid,
    output res_t             push_data
);

    pos_t        pos_reg, pos_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [15:0] len_reg, len_next;

    pos_t        pos;
    pos_t        nxt;
    pos_t        actual;
    logic [15:0] len_eff;
    logic        accept;
    logic        hdr_done;
    status_t     status;

    assign byte_ch.ready = push_ready;
    assign push_valid    = byte_ch.valid;
    assign accept        = byte_ch.valid && push_ready;

    always_comb
    begin
        pos      = (pos_reg > pos_t'(POS_SAT)) ? pos_t'(POS_SAT) : pos_reg;
        nxt      = (pos < pos_t'(POS_SAT)) ? pos + pos_t'(1) : pos_t'(POS_SAT);
        len_eff  = (pos == pos_t'(2)) ? {byte_ch.data_byte, len_low_reg} : len_reg;
        actual   = nxt - pos_t'(HDR_LEN);
        hdr_done = (nxt >= pos_t'(HDR_LEN));

        if (nxt > pos_t'(POS_LIMIT))
        begin
            status = ST_OVERLONG;
        end
        else if (!hdr_done)
        begin
            status = ST_SHORT_HDR;
        end
        else if (actual < pos_t'(len_eff))
        begin
            status = ST_SHORT_BODY;
        end
        else if (actual > pos_t'(len_eff))
        begin
            status = ST_TRAILING;
        end
        else
        begin
            status = ST_OK;
        end

        push_data.payload_valid = (pos >= pos_t'(HDR_LEN)) && (pos < pos_t'(POS_LIMIT))
                                  && ((pos - pos_t'(HDR_LEN)) < pos_t'(len_reg));
        push_data.payload_byte  = push_data.payload_valid ? byte_ch.data_byte : 8'd0;
        push_data.frame_end     = byte_ch.frame_last;
        push_data.frame_status  = byte_ch.frame_last ? status : ST_OK;
        push_data.frame_kind    = (byte_ch.frame_last && hdr_done) ? kind_reg : 8'd0;
        push_data.declared_length = (byte_ch.frame_last && hdr_done) ? len_eff : 16'd0;

        pos_next     = pos_reg;
        kind_next    = kind_reg;
        len_low_next = len_low_reg;
        len_next     = len_reg;
        if (accept)
        begin
            if (byte_ch.frame_last)
            begin
                pos_next     = '0;
                kind_next    = 8'd0;
                len_low_next = 8'd0;
                len_next     = 16'd0;
            end
            else
            begin
                pos_next = nxt;
                if (pos == pos_t'(0))
                begin
                    kind_next = byte_ch.data_byte;
                end
                if (pos == pos_t'(1))
                begin
                    len_low_next = byte_ch.data_byte;
                end
                if (pos == pos_t'(2))
                begin
                    len_next = len_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            kind_reg    <= 8'd0;
            len_low_reg <= 8'd0;
            len_reg     <= 16'd0;
        end
        else
        begin
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            len_low_reg <= len_low_next;
            len_reg     <= len_next;
        end
    end

endmodule

// ===== rtl/core/lpfc_outbuf.sv =====
// ----------------------------------------------------------------------------
// Frame checker output buffer
// Result register with a skid stage; ready toward the core is registered.
// ----------------------------------------------------------------------------
module lpfc_outbuf
    import lpfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  res_t             push_data,
    lpfc_result_if.source    result_ch
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic push;
    logic pop;

    assign push_ready = rst_n && !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && result_ch.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign result_ch.valid           = main_valid_reg;
    assign result_ch.payload_valid   = main_reg.payload_valid;
    assign result_ch.payload_byte    = main_reg.payload_byte;
    assign result_ch.frame_end       = main_reg.frame_end;
    assign result_ch.frame_status    = 3'(main_reg.frame_status);
    assign result_ch.frame_kind      = main_reg.frame_kind;
    assign result_ch.declared_length = main_reg.declared_length;

endmodule

// ===== rtl/core/lpfc_checker.sv =====
// ----------------------------------------------------------------------------
// Frame checker port assertions
// Checks result channel behavior seen at the top level ports.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_checker_top_defines.svh"

module lpfc_checker
    import lpfc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        frame_end,
    input logic [2:0]  frame_status,
    input logic [7:0]  frame_kind,
    input logic [15:0] declared_length
);

    `LPFC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `LPFC_ASSERT(a_status_only_at_end, out_valid && !frame_end |-> frame_status == 3'(ST_OK) && frame_kind == 8'd0 && declared_length == 16'd0, "frame fields set before frame end")
    `LPFC_ASSERT(a_short_hdr_fields, out_valid && frame_status == 3'(ST_SHORT_HDR) |-> frame_kind == 8'd0 && declared_length == 16'd0, "header fields set on short header")
    `LPFC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result present right after reset")

endmodule

bind length_prefixed_frame_checker_top lpfc_checker u_lpfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result_ch.valid),
    .out_ready       (result_ch.ready),
    .frame_end       (result_ch.frame_end),
    .frame_status    (result_ch.frame_status),
    .frame_kind      (result_ch.frame_kind),
    .declared_length (result_ch.declared_length)
);
